[rtl/vpv_pkg.sv]
// vpv_pkg: shared types, codes and helpers for the vertex project / viewport unit
// no dependencies

package vpv_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int STORE_DEPTH   = 48;

	// request types
	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_PROJECT = 1'b1;

	// matrix select codes, also the top two bits of a store address
	localparam logic [1:0] MSEL_WORLD = 2'd0;
	localparam logic [1:0] MSEL_VIEW  = 2'd1;
	localparam logic [1:0] MSEL_PROJ  = 2'd2;
	localparam logic [1:0] MSEL_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_VIEW_LEFT   = 3'd0;
	localparam logic [2:0] REG_VIEW_TOP    = 3'd1;
	localparam logic [2:0] REG_VIEW_WIDTH  = 3'd2;
	localparam logic [2:0] REG_VIEW_HEIGHT = 3'd3;
	localparam logic [2:0] REG_DEPTH_NEAR  = 3'd4;
	localparam logic [2:0] REG_DEPTH_FAR   = 3'd5;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	typedef struct packed {
		logic [15:0] view_left;
		logic [15:0] view_top;
		logic [15:0] view_width;
		logic [15:0] view_height;
		logic [16:0] depth_near;
		logic [16:0] depth_far;
	} vpv_cfg_t;

	typedef struct packed {
		logic               is_proj;
		logic [5:0]         addr;
		logic signed [31:0] data;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} vpv_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} vpv_qstat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'(SAT_MAX))
			return SAT_MAX;
		else if (v < 64'(SAT_MIN))
			return SAT_MIN;
		else
			return v[31:0];
	endfunction

endpackage

[rtl/vertex_project_viewport_unit.sv]
// vertex_project_viewport_unit: top level, configuration registers and wiring
// depends on vpv_pkg, vpv_front, vpv_queue, vpv_back
//
// input channel (in_valid / in_ready): an item writes one matrix element
//   (req_type 0, world / view / projection by matrix_select) or projects a vertex
//   (req_type 1) through world * view * projection, divide by w and viewport map
// output channel (out_valid / out_ready): one item per projected vertex
// config channel (cfg_valid / cfg_ready): always ready, writes the viewport and
//   depth registers by index; unknown indexes are ignored
// processing: a project item runs through the shared multiply-accumulate (two
//   64-step matrix products and a 16-step vertex transform, each followed by a
//   drain), then the bit-serial divider for each component (the quotient
//   saturates when w is zero) and the viewport map; a write item only updates the store
// throughput: one project item at a time; a two-entry queue lets the front keep
//   taking items while the back works
// reset: matrices read as identity until written, registers take their defaults
// stall: a result waits in the output register while out_ready is low, the back
//   end holds and the queue fills, then in_ready drops

module vertex_project_viewport_unit import vpv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [1:0]         matrix_select,
	input  logic [1:0]         row_index,
	input  logic [1:0]         column_index,
	input  logic signed [31:0] element_value,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [31:0] screen_depth,
	output logic               w_zero,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	vpv_cfg_t   cfg_q;
	vpv_qstat_t q_stat;
	vpv_item_t  push_item, pop_item;
	logic       q_push, q_pop;

	// config writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view_left   <= 16'd0;
			cfg_q.view_top    <= 16'd0;
			cfg_q.view_width  <= 16'd640;
			cfg_q.view_height <= 16'd480;
			cfg_q.depth_near  <= 17'd0;
			cfg_q.depth_far   <= 17'd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VIEW_LEFT:   cfg_q.view_left   <= cfg_data[15:0];
				REG_VIEW_TOP:    cfg_q.view_top    <= cfg_data[15:0];
				REG_VIEW_WIDTH:  cfg_q.view_width  <= cfg_data[15:0];
				REG_VIEW_HEIGHT: cfg_q.view_height <= cfg_data[15:0];
				REG_DEPTH_NEAR:  cfg_q.depth_near  <= cfg_data[16:0];
				REG_DEPTH_FAR:   cfg_q.depth_far   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// front: accept and classify
	vpv_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.matrix_select (matrix_select),
		.row_index     (row_index),
		.column_index  (column_index),
		.element_value (element_value),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.vertex_z      (vertex_z),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	// queue decoupling front and back
	vpv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (push_item),
		.pop      (q_pop),
		.item_out (pop_item),
		.q_stat   (q_stat)
	);

	// back: store, arithmetic and output register
	vpv_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_item       (pop_item),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.screen_depth (screen_depth),
		.w_zero       (w_zero)
	);

endmodule

[rtl/vpv_front.sv]
// vpv_front: accepts input items, classifies them and builds queue entries
// depends on vpv_pkg

module vpv_front import vpv_pkg::*; (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [1:0]         matrix_select,
	input  logic [1:0]         row_index,
	input  logic [1:0]         column_index,
	input  logic signed [31:0] element_value,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  vpv_qstat_t         q_stat,
	output logic               q_push,
	output vpv_item_t          q_item
);

	logic drop;

	// writes to the unused matrix select are consumed and dropped
	assign drop     = (req_type == REQ_WRITE) && (matrix_select == MSEL_NONE);
	assign in_ready = !q_stat.full;
	assign q_push   = in_valid && in_ready && !drop;

	always_comb begin
		q_item.is_proj = (req_type == REQ_PROJECT);
		q_item.addr    = {matrix_select, row_index, column_index};
		q_item.data    = element_value;
		q_item.vx      = vertex_x;
		q_item.vy      = vertex_y;
		q_item.vz      = vertex_z;
	end

endmodule

[rtl/vpv_queue.sv]
// vpv_queue: short item queue between front and back
// depends on vpv_pkg

module vpv_queue import vpv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  vpv_item_t  item_in,
	input  logic       pop,
	output vpv_item_t  item_out,
	output vpv_qstat_t q_stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	vpv_item_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign q_stat.full  = (count_q == CNT_FULL);
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign item_out     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/vpv_back.sv]
// vpv_back: matrix store, shared multiply-accumulate, divider and viewport map
// depends on vpv_pkg

module vpv_back import vpv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vpv_cfg_t           cfg,
	input  vpv_item_t          q_item,
	input  vpv_qstat_t         q_stat,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [31:0] screen_depth,
	output logic               w_zero
);

	localparam int ACC_W = 66 - FRAC_BITS;
	localparam int DVD_W = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam int PV_W  = (34 + FRAC_BITS > 50) ? 34 + FRAC_BITS : 50;
	localparam int NF_W  = FRAC_BITS + 1;
	localparam int DZ_W  = FRAC_BITS + 2;
	localparam int DW    = 17 + FRAC_BITS;
	localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);
	localparam logic [DVD_W-1:0] Q_POS_MAX = DVD_W'(64'h7fffffff);
	localparam logic [DVD_W-1:0] Q_NEG_MAX = DVD_W'(64'h80000000);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MAC     = 4'd1;
	localparam logic [3:0] ST_DRAIN   = 4'd2;
	localparam logic [3:0] ST_DIV_LD  = 4'd3;
	localparam logic [3:0] ST_DIV_RUN = 4'd4;
	localparam logic [3:0] ST_DIV_FIN = 4'd5;
	localparam logic [3:0] ST_VP0     = 4'd6;
	localparam logic [3:0] ST_VP1     = 4'd7;
	localparam logic [3:0] ST_VP2     = 4'd8;
	localparam logic [3:0] ST_VP3     = 4'd9;

	localparam logic [1:0] PH_WV = 2'd0;
	localparam logic [1:0] PH_CB = 2'd1;
	localparam logic [1:0] PH_TV = 2'd2;

	logic [3:0] state_q;
	logic [1:0] ph_q, r_q, c_q, k_q, qi_q;

	logic [31:0]             mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0]  vld_q;
	logic signed [31:0]      wv_q [16];
	logic signed [31:0]      cb_q [16];
	logic signed [31:0]      t_q [4];
	logic signed [31:0]      vx_q [3];
	logic signed [31:0]      quo_q [3];

	// mac pipeline
	logic               v_s1, first_s1, last_s1, va_s1, vb_s1, da_s1, db_s1;
	logic [1:0]         ph_s1;
	logic [3:0]         dest_s1;
	logic signed [31:0] opa_s1, opb_s1, ma_s1, mb_s1;
	logic               v_s2, first_s2, last_s2;
	logic [1:0]         ph_s2;
	logic [3:0]         dest_s2;
	logic signed [63:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q, acc_next;
	logic signed [31:0] acc_sat;

	// divider
	logic [DVD_W-1:0] dvd_q;
	logic [31:0]      dsr_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [32:0]      rem_sh;
	logic             ge;

	// viewport
	logic signed [PV_W-1:0] pv_q;
	logic signed [31:0]     sx_q, sy_q;
	logic [DW-1:0]          nf_full, ff_full;
	logic [NF_W-1:0]        nf, ff;
	logic signed [DZ_W-1:0] dz;
	logic signed [32:0]     opx, opy;

	logic               issue, last_issue, wr_en, proj_start;
	logic [5:0]         ra, rb;
	logic signed [31:0] opa, opb, a_sel, b_sel, num, wdiv;
	logic [31:0]        num_abs, w_abs;
	logic [5:0]         rck_next;

	assign q_pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign wr_en      = q_pop && !q_item.is_proj;
	assign proj_start = q_pop && q_item.is_proj;
	assign issue      = (state_q == ST_MAC);
	assign last_issue = (c_q == 2'd3) && (k_q == 2'd3) && ((r_q == 2'd3) || (ph_q == PH_TV));
	assign rck_next   = {r_q, c_q, k_q} + 6'd1;

	// operand addresses and non-store operands
	always_comb begin
		ra  = {MSEL_WORLD, r_q, k_q};
		rb  = {(ph_q == PH_WV) ? MSEL_VIEW : MSEL_PROJ, k_q, c_q};
		opb = cb_q[{k_q, c_q}];
		if (ph_q == PH_CB)
			opa = wv_q[{r_q, k_q}];
		else begin
			// translation row of the vertex transform uses w of one
			case (k_q)
				2'd0:    opa = vx_q[0];
				2'd1:    opa = vx_q[1];
				2'd2:    opa = vx_q[2];
				default: opa = ONE;
			endcase
		end
	end

	// store: write port plus two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[q_item.addr] <= q_item.data;
		ma_s1 <= mem[ra];
		mb_s1 <= mem[rb];
		va_s1 <= vld_q[ra];
		vb_s1 <= vld_q[rb];
	end

	// entries never written read as identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (wr_en)
			vld_q[q_item.addr] <= 1'b1;
	end

	always_comb begin
		if (ph_s1 == PH_WV)
			a_sel = va_s1 ? ma_s1 : (da_s1 ? ONE : '0);
		else
			a_sel = opa_s1;
		if (ph_s1 == PH_TV)
			b_sel = opb_s1;
		else
			b_sel = vb_s1 ? mb_s1 : (db_s1 ? ONE : '0);
	end

	assign acc_next = (first_s2 ? '0 : acc_q) + ACC_W'(prod_s2 >>> FRAC_BITS);
	assign acc_sat  = sat32(64'(acc_next));

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == 2'd0);
		last_s1  <= (k_q == 2'd3);
		ph_s1    <= ph_q;
		dest_s1  <= (ph_q == PH_TV) ? {2'b00, c_q} : {r_q, c_q};
		opa_s1   <= opa;
		opb_s1   <= opb;
		da_s1    <= (r_q == k_q);
		db_s1    <= (k_q == c_q);
		prod_s2  <= a_sel * b_sel;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		ph_s2    <= ph_s1;
		dest_s2  <= dest_s1;
		if (v_s2) begin
			acc_q <= acc_next;
			if (last_s2) begin
				case (ph_s2)
					PH_WV:   wv_q[dest_s2] <= acc_sat;
					PH_CB:   cb_q[dest_s2] <= acc_sat;
					default: t_q[dest_s2[1:0]] <= acc_sat;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// divider datapath
	assign num     = t_q[qi_q];
	assign wdiv    = t_q[3];
	assign num_abs = num[31] ? 32'(-num) : 32'(num);
	assign w_abs   = wdiv[31] ? 32'(-wdiv) : 32'(wdiv);
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = (rem_sh >= {1'b0, dsr_q});

	// viewport operands
	assign nf_full = {cfg.depth_near, {FRAC_BITS{1'b0}}} >> 16;
	assign ff_full = {cfg.depth_far, {FRAC_BITS{1'b0}}} >> 16;
	assign nf      = nf_full[NF_W-1:0];
	assign ff      = ff_full[NF_W-1:0];
	assign dz      = $signed({1'b0, ff}) - $signed({1'b0, nf});
	assign opx     = 33'(ONE) + 33'(quo_q[0]);
	assign opy     = 33'(ONE) - 33'(quo_q[1]);

	always_ff @(posedge clk) begin
		if (proj_start) begin
			vx_q[0] <= q_item.vx;
			vx_q[1] <= q_item.vy;
			vx_q[2] <= q_item.vz;
		end
		case (state_q)
			ST_DIV_LD: begin
				if (wdiv == '0)
					quo_q[qi_q] <= num[31] ? SAT_MIN : SAT_MAX;
				dvd_q <= DVD_W'(num_abs) << FRAC_BITS;
				dsr_q <= w_abs;
				rem_q <= '0;
				neg_q <= num[31] ^ wdiv[31];
			end
			ST_DIV_RUN: begin
				rem_q <= ge ? 32'(rem_sh - {1'b0, dsr_q}) : rem_sh[31:0];
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
			end
			ST_DIV_FIN: begin
				if (neg_q)
					quo_q[qi_q] <= (dvd_q > Q_NEG_MAX) ? SAT_MIN : 32'(-dvd_q);
				else
					quo_q[qi_q] <= (dvd_q > Q_POS_MAX) ? SAT_MAX : 32'(dvd_q);
			end
			ST_VP0: pv_q <= PV_W'(opx) * PV_W'($signed({1'b0, cfg.view_width}));
			ST_VP1: begin
				sx_q <= sat32((64'(cfg.view_left) << FRAC_BITS) + 64'(pv_q >>> 1));
				pv_q <= PV_W'(opy) * PV_W'($signed({1'b0, cfg.view_height}));
			end
			ST_VP2: begin
				sy_q <= sat32((64'(cfg.view_top) << FRAC_BITS) + 64'(pv_q >>> 1));
				pv_q <= PV_W'(quo_q[2]) * PV_W'(dz);
			end
			ST_VP3: begin
				if (!out_valid || out_ready) begin
					screen_x     <= sx_q;
					screen_y     <= sy_q;
					screen_depth <= sat32(64'(nf) + 64'(pv_q >>> FRAC_BITS));
					w_zero       <= (wdiv == '0);
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ph_q      <= PH_WV;
			r_q       <= '0;
			c_q       <= '0;
			k_q       <= '0;
			qi_q      <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// a new result replaces the one being taken in the same cycle
			if ((state_q == ST_VP3) && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (proj_start) begin
						ph_q    <= PH_WV;
						{r_q, c_q, k_q} <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					{r_q, c_q, k_q} <= rck_next;
					if (last_issue)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						{r_q, c_q, k_q} <= '0;
						if (ph_q == PH_TV) begin
							qi_q    <= '0;
							state_q <= ST_DIV_LD;
						end else begin
							ph_q    <= ph_q + 2'd1;
							state_q <= ST_MAC;
						end
					end
				end
				ST_DIV_LD: begin
					cnt_q <= '0;
					if (wdiv == '0) begin
						qi_q    <= qi_q + 2'd1;
						state_q <= (qi_q == 2'd2) ? ST_VP0 : ST_DIV_LD;
					end else
						state_q <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= ST_DIV_FIN;
				end
				ST_DIV_FIN: begin
					qi_q    <= qi_q + 2'd1;
					state_q <= (qi_q == 2'd2) ? ST_VP0 : ST_DIV_LD;
				end
				ST_VP0: state_q <= ST_VP1;
				ST_VP1: state_q <= ST_VP2;
				ST_VP2: state_q <= ST_VP3;
				ST_VP3: begin
					if (!out_valid || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/vpv_checker.sv]
// vpv_checker: port-level checks for vertex_project_viewport_unit, with bind
// depends on vertex_project_viewport_unit ports only

module vpv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] screen_x,
	input logic [31:0] screen_y,
	input logic [31:0] screen_depth,
	input logic        w_zero,
	input logic        cfg_ready
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
			&& $stable(screen_depth) && $stable(w_zero))
		else $error("output item changed while stalled");

	// a result only leaves when taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("output item dropped without handshake");

	// no result during reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// config port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind vertex_project_viewport_unit vpv_checker u_vpv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.screen_x     (screen_x),
	.screen_y     (screen_y),
	.screen_depth (screen_depth),
	.w_zero       (w_zero),
	.cfg_ready    (cfg_ready)
);
